// ----- design/svpwm_pkg.sv -----
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared types, constants and the sine table generator for the SVPWM duty
// calculation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package svpwm_pkg;

  // Configuration register indexes
  localparam logic REG_PERIOD  = 1'b0;
  localparam logic REG_ROT_DIR = 1'b1;

  localparam int ANGLE_LIMIT  = 360;
  localparam int SECTOR_SPAN  = 60;
  localparam int PROD_SHIFT   = 8;
  localparam int ROM_DEPTH    = 61;

  // Q31 constants for the Taylor series sine
  localparam logic [63:0] PI_Q31   = 64'd6746518852;
  localparam logic [63:0] HALF_Q31 = 64'd1073741824;
  localparam logic [63:0] TAYLOR_DIV [1:10] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
    64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };

  typedef struct packed {
    logic [15:0] period;
    logic        rotation_dir;
  } cfg_t;

  // decode stage -> multiply stage
  typedef struct packed {
    logic [15:0] amplitude;
    logic [15:0] rom_t1;     // S(60 - offset in sector)
    logic [15:0] rom_t2;     // S(offset in sector)
    logic [2:0]  sector;
    logic        ok;
  } dec_t;

  // multiply stage -> phase stage
  typedef struct packed {
    logic [23:0] t1_raw;
    logic [23:0] t2_raw;
    logic [2:0]  sector;
    logic        ok;
  } mul_t;

  // round(scale * sin(k deg)), evaluated at elaboration only
  function automatic logic [15:0] sine_rom(input logic [31:0] scale, input int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] rv;
    int          n;
    x    = (PI_Q31 * 64'(k) + 64'd90) / 64'd180;
    x2   = (x * x + HALF_Q31) >> 31;
    term = x;
    sum  = x;
    for (n = 1; n <= 10; n++) begin
      term = ((term * x2 + HALF_Q31) >> 31) / TAYLOR_DIV[n];
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (k == 0) begin
      rv = 64'd0;
    end else if (k == 30) begin
      rv = (64'(scale) + 64'd1) >> 1;
    end else begin
      rv = (64'(scale) * sum + HALF_Q31) >> 31;
    end
    return rv[15:0];
  endfunction

endpackage

`default_nettype wire

// ----- design/svpwm_decode.sv -----
// ----------------------------------------------------------------------------
// svpwm_decode
// Range check, sector split and sine table lookup; registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_decode #(
  parameter int SINE_SCALE = 256
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [15:0]       angle,
  input  wire logic [15:0]       amplitude,
  output svpwm_pkg::dec_t        dec
);
  import svpwm_pkg::*;

  logic [15:0] rom [0:ROM_DEPTH-1];

  for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_rom
    assign rom[k] = sine_rom(32'(SINE_SCALE), k);
  end

  logic       ok;
  logic [8:0] a9;
  logic [2:0] sector;
  logic [8:0] base;
  logic [5:0] sub_angle;
  logic [5:0] idx_t1;

  assign ok = (angle < 16'(ANGLE_LIMIT));
  assign a9 = angle[8:0];

  always_comb begin
    if (a9 >= 9'(5 * SECTOR_SPAN)) begin
      sector = 3'd5;
    end else if (a9 >= 9'(4 * SECTOR_SPAN)) begin
      sector = 3'd4;
    end else if (a9 >= 9'(3 * SECTOR_SPAN)) begin
      sector = 3'd3;
    end else if (a9 >= 9'(2 * SECTOR_SPAN)) begin
      sector = 3'd2;
    end else if (a9 >= 9'(SECTOR_SPAN)) begin
      sector = 3'd1;
    end else begin
      sector = 3'd0;
    end
  end

  assign base = 9'(SECTOR_SPAN) * 9'(sector);

  // Out-of-range angles point at entry 0 so the lookup stays in the table.
  always_comb begin
    logic [8:0] diff;
    diff      = a9 - base;
    sub_angle = ok ? diff[5:0] : 6'd0;
    idx_t1    = 6'(SECTOR_SPAN) - sub_angle;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec.amplitude <= amplitude;
      dec.rom_t1    <= rom[idx_t1];
      dec.rom_t2    <= rom[sub_angle];
      dec.sector    <= ok ? sector : 3'd0;
      dec.ok        <= ok;
    end
  end

endmodule

`default_nettype wire

// ----- design/svpwm_times.sv -----
// ----------------------------------------------------------------------------
// svpwm_times
// Raw active times: amplitude times sine entry, shifted; registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_times (
  input  wire logic              clk,
  input  wire logic              en,
  input  svpwm_pkg::dec_t        dec,
  output svpwm_pkg::mul_t        mul
);
  import svpwm_pkg::*;

  logic [31:0] p1;
  logic [31:0] p2;

  assign p1 = 32'(dec.amplitude) * 32'(dec.rom_t1);
  assign p2 = 32'(dec.amplitude) * 32'(dec.rom_t2);

  always_ff @(posedge clk) begin
    if (en) begin
      mul.t1_raw <= p1[31:PROD_SHIFT];
      mul.t2_raw <= p2[31:PROD_SHIFT];
      mul.sector <= dec.sector;
      mul.ok     <= dec.ok;
    end
  end

endmodule

`default_nettype wire

// ----- design/svpwm_phase.sv -----
// ----------------------------------------------------------------------------
// svpwm_phase
// Clamp, zero time and per-sector phase assignment; drives the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_phase (
  input  wire logic              clk,
  input  wire logic              en,
  input  svpwm_pkg::mul_t        mul,
  input  svpwm_pkg::cfg_t        cfg,
  output logic [16:0]            duty_a,
  output logic [16:0]            duty_b,
  output logic [16:0]            duty_c,
  output logic [2:0]             sector_num,
  output logic                   angle_ok
);
  import svpwm_pkg::*;

  logic [15:0] t1;
  logic [15:0] t2;
  logic [16:0] t_sum;
  logic [16:0] diff;
  logic [14:0] t0;
  logic        t1_first;
  logic [15:0] first;
  logic [15:0] second;
  logic [16:0] d_low;
  logic [16:0] d_mid;
  logic [16:0] d_hi;
  logic [16:0] a_next;
  logic [16:0] b_next;
  logic [16:0] c_next;

  assign t1 = (mul.t1_raw > 24'(cfg.period)) ? cfg.period : mul.t1_raw[15:0];
  assign t2 = (mul.t2_raw > 24'(cfg.period)) ? cfg.period : mul.t2_raw[15:0];

  assign t_sum = 17'(t1) + 17'(t2);
  assign diff  = 17'(cfg.period) - t_sum;
  // negative remainder saturates at zero
  assign t0    = diff[16] ? 15'd0 : diff[15:1];

  assign t1_first = (mul.sector[0] == 1'b0) == cfg.rotation_dir;
  assign first    = t1_first ? t1 : t2;
  assign second   = t1_first ? t2 : t1;

  assign d_low = 17'(t0);
  assign d_mid = d_low + 17'(first);
  assign d_hi  = d_mid + 17'(second);

  always_comb begin
    case (mul.sector)
      3'd0: begin a_next = d_low; b_next = d_mid; c_next = d_hi;  end
      3'd1: begin a_next = d_mid; b_next = d_low; c_next = d_hi;  end
      3'd2: begin a_next = d_hi;  b_next = d_low; c_next = d_mid; end
      3'd3: begin a_next = d_hi;  b_next = d_mid; c_next = d_low; end
      3'd4: begin a_next = d_mid; b_next = d_hi;  c_next = d_low; end
      3'd5: begin a_next = d_low; b_next = d_hi;  c_next = d_mid; end
      default: begin a_next = d_low; b_next = d_mid; c_next = d_hi; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      duty_a     <= mul.ok ? a_next : 17'd0;
      duty_b     <= mul.ok ? b_next : 17'd0;
      duty_c     <= mul.ok ? c_next : 17'd0;
      sector_num <= mul.ok ? mul.sector : 3'd0;
      angle_ok   <= mul.ok;
    end
  end

endmodule

`default_nettype wire

// ----- design/svpwm_duty_calc_unit.sv -----
// ----------------------------------------------------------------------------
// svpwm_duty_calc_unit
// Space-vector PWM duty calculation: angle and amplitude in, three phase
// compare values, sector and angle-valid flag out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  : in_valid / in_stall carry one beat of {angle, amplitude}.
//   Output channel : out_valid / out_stall carry one beat of
//                    {duty_a, duty_b, duty_c, sector_num, angle_ok}.
//   Config port    : cfg_we, cfg_index, cfg_data; index 0 is the PWM period
//                    count, index 1 is rotation_dir (bit 0). Write only when idle.
//   Pipeline       : input reg -> decode/ROM reg -> multiply reg -> result reg.
//   Throughput     : one beat per cycle while out_stall is low, set by the
//                    four-stage pipeline with one ROM read pair and one multiplier pair per beat.
//   Angles of 360 or more give angle_ok = 0 with zero duties and sector 0;
//   the consumer keeps its previous compare values.
//   Reset          : all stage valids clear, registers return to
//                    period = 1000 and rotation_dir = 1.
//   Stall          : when out_stall holds a result, stages keep filling until
//                    every stage is full, then in_stall rises. Bubbles are
//                    squeezed out, so no beat is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_duty_calc_unit #(
  parameter int SINE_SCALE = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // config
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] angle,
  input  wire logic [15:0] amplitude,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [16:0]      duty_a,
  output logic [16:0]      duty_b,
  output logic [16:0]      duty_c,
  output logic [2:0]       sector_num,
  output logic             angle_ok
);
  import svpwm_pkg::*;

  // Config registers
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period       <= 16'd1000;
      cfg.rotation_dir <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PERIOD:  cfg.period       <= cfg_data;
        REG_ROT_DIR: cfg.rotation_dir <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage valids and advance chain. A stage loads when it is empty or the
  // stage after it moves on this cycle.
  logic v_in;
  logic v_dec;
  logic v_mul;
  logic adv_out;
  logic adv_mul;
  logic adv_dec;
  logic adv_in;

  assign adv_out = !out_valid || !out_stall;
  assign adv_mul = !v_mul || adv_out;
  assign adv_dec = !v_dec || adv_mul;
  assign adv_in  = !v_in  || adv_dec;
  assign in_stall = !adv_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in      <= 1'b0;
      v_dec     <= 1'b0;
      v_mul     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_in)  v_in      <= in_valid;
      if (adv_dec) v_dec     <= v_in;
      if (adv_mul) v_mul     <= v_dec;
      if (adv_out) out_valid <= v_mul;
    end
  end

  // Input register (payload only)
  logic [15:0] angle_q;
  logic [15:0] amplitude_q;

  always_ff @(posedge clk) begin
    if (adv_in) begin
      angle_q     <= angle;
      amplitude_q <= amplitude;
    end
  end

  dec_t dec;
  mul_t mul;

  svpwm_decode #(
    .SINE_SCALE (SINE_SCALE)
  ) u_decode (
    .clk       (clk),
    .en        (adv_dec),
    .angle     (angle_q),
    .amplitude (amplitude_q),
    .dec       (dec)
  );

  svpwm_times u_times (
    .clk (clk),
    .en  (adv_mul),
    .dec (dec),
    .mul (mul)
  );

  svpwm_phase u_phase (
    .clk        (clk),
    .en         (adv_out),
    .mul        (mul),
    .cfg        (cfg),
    .duty_a     (duty_a),
    .duty_b     (duty_b),
    .duty_c     (duty_c),
    .sector_num (sector_num),
    .angle_ok   (angle_ok)
  );

endmodule

`default_nettype wire

// ----- design/svpwm_duty_calc_unit_chk.sv -----
// ----------------------------------------------------------------------------
// svpwm_chk
// Port-level checks for the SVPWM duty calculation unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [16:0] duty_a,
  input wire logic [16:0] duty_b,
  input wire logic [16:0] duty_c,
  input wire logic [2:0]  sector_num,
  input wire logic        angle_ok
);

  // a held result beat stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  // bad angle gives an all-zero result
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !angle_ok |->
      duty_a == 17'd0 && duty_b == 17'd0 && duty_c == 17'd0 && sector_num == 3'd0)
    else $error("nonzero result for out-of-range angle");

  // sector 0 orders a <= b <= c, sector 3 orders c <= b <= a
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && angle_ok && sector_num == 3'd0 |-> duty_a <= duty_b && duty_b <= duty_c)
    else $error("phase order wrong in sector 0");

  a_order3: assert property (@(posedge clk) disable iff (rst)
    out_valid && angle_ok && sector_num == 3'd3 |-> duty_c <= duty_b && duty_b <= duty_a)
    else $error("phase order wrong in sector 3");

  // nothing is offered in the cycle after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind svpwm_duty_calc_unit svpwm_chk u_svpwm_chk (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .duty_a     (duty_a),
  .duty_b     (duty_b),
  .duty_c     (duty_c),
  .sector_num (sector_num),
  .angle_ok   (angle_ok)
);

`default_nettype wire
